// ----- design/mbe_pkg.sv -----
// shared widths, datapath step codes and controller/datapath handshake structs
package mbe_pkg;

    // fixed field widths
    localparam int IDX_W   = 10;
    localparam int STEP_W  = 30;
    localparam int COUNT_W = 25;
    localparam int Q_W     = 32;
    localparam int FRAC    = 28;

    // datapath step selected by the controller each cycle
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_COORD,
        OP_CSAT,
        OP_SQUARE,
        OP_XPSQ,
        OP_QSUM,
        OP_LHS,
        OP_DECIDE,
        OP_ITER_MUL,
        OP_ITER_UPD
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_set;
        logic lim_hit;
        logic escaped;
    } dp_status_t;

endpackage

// ----- design/mbe_datapath.sv -----
// coordinate mapping, known-region test and z iteration datapath
module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [IDX_W-1:0]    column,
    input  logic [IDX_W-1:0]    row,
    input  logic [COUNT_W-1:0]  max_iter,
    input  logic [STEP_W-1:0]   x_step,
    input  logic [STEP_W-1:0]   y_step,
    output logic [COUNT_W-1:0]  count
);

    localparam int MUL_W  = Q_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int COL_LAST = MAX_COLUMNS - 1;
    localparam int ROW_LAST = MAX_ROWS - 1;
    localparam int IDX_TOP  = (1 << IDX_W) - 1;
    localparam logic [IDX_W-1:0] COL_LIM = IDX_W'((COL_LAST > IDX_TOP) ? IDX_TOP : COL_LAST);
    localparam logic [IDX_W-1:0] ROW_LIM = IDX_W'((ROW_LAST > IDX_TOP) ? IDX_TOP : ROW_LAST);

    // Q4.28 constants
    localparam logic signed [Q_W-1:0]   CR_BASE  = 32'shE000_0000;  // -2
    localparam logic signed [Q_W-1:0]   CI_BASE  = 32'shEE00_0000;  // -1.125
    localparam logic signed [Q_W-1:0]   WIN_LO   = 32'shF400_0000;  // -0.75
    localparam logic signed [Q_W-1:0]   WIN_HI_R = 32'sh0800_0000;  // 0.5
    localparam logic signed [Q_W-1:0]   WIN_HI_I = 32'sh0C00_0000;  // 0.75
    localparam logic signed [MUL_W-1:0] ONE_Q    = 33'sh0_1000_0000;
    localparam logic signed [MUL_W-1:0] QUARTER  = 33'sh0_0400_0000;
    localparam logic signed [Q_W-1:0]   Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]   Q_MIN    = 32'sh8000_0000;
    // Q12.56 thresholds
    localparam logic signed [SUM_W-1:0] SIXTEENTH_SQ = SUM_W'(64'd1 << 52);
    localparam logic signed [SUM_W-1:0] FOUR_SQ      = SUM_W'(64'd1 << 58);

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SUM_W'(Q_MAX))
            r = Q_MAX;
        else if (v < SUM_W'(Q_MIN))
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    logic [IDX_W-1:0]          col_reg, row_reg;
    logic signed [Q_W-1:0]     cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg, ci2_reg;
    logic signed [PROD_W-1:0]  p0_next, p1_next, p2_next;
    logic signed [MUL_W-1:0]   q_reg, q_next;
    logic                      disc_reg, win_reg;
    logic [COUNT_W-1:0]        n_reg;

    logic signed [MUL_W-1:0]   a0, b0, a1, b1, a2, b2;
    logic signed [MUL_W-1:0]   cr_ext, ci_ext, cr_p1, xp, qx;
    logic signed [SUM_W-1:0]   qsum, esc_sum, nr_wide, ni_wide;
    logic signed [Q_W-1:0]     cr_next, ci_next, zr_next, zi_next;
    logic                      disc, win, lhs_lt, escaped;
    logic [IDX_W-1:0]          col_clamp, row_clamp;

    // index clamp to the configured image size
    assign col_clamp = (column > COL_LIM) ? COL_LIM : column;
    assign row_clamp = (row > ROW_LIM) ? ROW_LIM : row;

    // derived operands
    assign cr_ext = MUL_W'(cr_reg);
    assign ci_ext = MUL_W'(ci_reg);
    assign cr_p1  = cr_ext + ONE_Q;
    assign xp     = cr_ext - QUARTER;
    assign qx     = q_reg + xp;

    // operand select for the three shared multipliers
    always_comb
    begin
        a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
        case (cmd.op)
            OP_COORD:
            begin
                a0 = MUL_W'(col_reg); b0 = MUL_W'(x_step);
                a1 = MUL_W'(row_reg); b1 = MUL_W'(y_step);
            end
            OP_SQUARE:
            begin
                a0 = cr_ext; b0 = cr_ext;
                a1 = cr_p1;  b1 = cr_p1;
                a2 = ci_ext; b2 = ci_ext;
            end
            OP_XPSQ:
            begin
                a0 = xp; b0 = xp;
            end
            OP_LHS:
            begin
                a0 = q_reg; b0 = qx;
            end
            OP_ITER_MUL:
            begin
                a0 = MUL_W'(zr_reg); b0 = MUL_W'(zr_reg);
                a1 = MUL_W'(zi_reg); b1 = MUL_W'(zi_reg);
                a2 = MUL_W'(zr_reg); b2 = MUL_W'(zi_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign p0_next = a0 * b0;
    assign p1_next = a1 * b1;
    assign p2_next = a2 * b2;

    // pixel coordinates from the registered products
    assign cr_next = sat_q(SUM_W'(CR_BASE) + SUM_W'(p0_reg));
    assign ci_next = sat_q(SUM_W'(CI_BASE) + SUM_W'(p1_reg));

    // disc tests and cardioid window
    assign disc = (SUM_W'(p0_reg) + SUM_W'(p2_reg) < SIXTEENTH_SQ) ||
                  (SUM_W'(p1_reg) + SUM_W'(p2_reg) < SIXTEENTH_SQ);
    assign win  = (cr_reg > WIN_LO) && (cr_reg < WIN_HI_R) &&
                  (ci_reg > WIN_LO) && (ci_reg < WIN_HI_I);

    // cardioid q, rounded down to Q4.28
    assign qsum   = SUM_W'(p0_reg) + SUM_W'(ci2_reg);
    assign q_next = MUL_W'(qsum >>> FRAC);
    assign lhs_lt = SUM_W'(p0_reg) < (SUM_W'(ci2_reg) >>> 2);

    // escape test and next z
    assign esc_sum = SUM_W'(p0_reg) + SUM_W'(p1_reg);
    assign escaped = esc_sum >= FOUR_SQ;
    assign nr_wide = ((SUM_W'(p0_reg) - SUM_W'(p1_reg)) >>> FRAC) + SUM_W'(cr_reg);
    assign ni_wide = (SUM_W'(p2_reg) >>> (FRAC - 1)) + SUM_W'(ci_reg);
    assign zr_next = sat_q(nr_wide);
    assign zi_next = sat_q(ni_wide);

    // status to the controller
    assign status.in_set  = disc_reg || (win_reg && lhs_lt);
    assign status.lim_hit = n_reg >= max_iter;
    assign status.escaped = escaped;
    assign count          = n_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        case (cmd.op)
            OP_LOAD:
            begin
                col_reg <= col_clamp;
                row_reg <= row_clamp;
                zr_reg  <= '0;
                zi_reg  <= '0;
                n_reg   <= '0;
            end
            OP_CSAT:
            begin
                cr_reg <= cr_next;
                ci_reg <= ci_next;
            end
            OP_XPSQ:
            begin
                disc_reg <= disc;
                win_reg  <= win;
                ci2_reg  <= p2_reg;
            end
            OP_QSUM:
            begin
                q_reg <= q_next;
            end
            OP_DECIDE:
            begin
                if (status.in_set)
                    n_reg <= max_iter;
            end
            OP_ITER_UPD:
            begin
                if (!escaped)
                begin
                    zr_reg <= zr_next;
                    zi_reg <= zi_next;
                    n_reg  <= n_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // each survived iteration adds exactly one to the count
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ITER_UPD && !status.escaped) |=> n_reg == $past(n_reg) + 1'b1)
        else $error("iteration count did not advance by one");

    // a known-inside point reports the limit
    a_inside_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DECIDE && status.in_set) |=> n_reg == $past(max_iter))
        else $error("inside point did not load the iteration limit");

endmodule

// ----- design/mbe_ctrl.sv -----
// sequencing state machine for one pixel at a time
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_COORD    = 11'b000_0000_0010,
        ST_CSAT     = 11'b000_0000_0100,
        ST_SQUARE   = 11'b000_0000_1000,
        ST_XPSQ     = 11'b000_0001_0000,
        ST_QSUM     = 11'b000_0010_0000,
        ST_LHS      = 11'b000_0100_0000,
        ST_DECIDE   = 11'b000_1000_0000,
        ST_ITER_MUL = 11'b001_0000_0000,
        ST_ITER_UPD = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // next state and step command
    always_comb
    begin
        state_next      = state_reg;
        pixel_ready     = 1'b0;
        cmd.op          = OP_IDLE;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_COORD;
                end
            end
            ST_COORD:
            begin
                cmd.op     = OP_COORD;
                state_next = ST_CSAT;
            end
            ST_CSAT:
            begin
                cmd.op     = OP_CSAT;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = ST_XPSQ;
            end
            ST_XPSQ:
            begin
                cmd.op     = OP_XPSQ;
                state_next = ST_QSUM;
            end
            ST_QSUM:
            begin
                cmd.op     = OP_QSUM;
                state_next = ST_LHS;
            end
            ST_LHS:
            begin
                cmd.op     = OP_LHS;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = status.in_set ? ST_DONE : ST_ITER_MUL;
            end
            ST_ITER_MUL:
            begin
                cmd.op     = OP_ITER_MUL;
                state_next = status.lim_hit ? ST_DONE : ST_ITER_UPD;
            end
            ST_ITER_UPD:
            begin
                cmd.op     = OP_ITER_UPD;
                state_next = status.escaped ? ST_DONE : ST_ITER_MUL;
            end
            ST_DONE:
            begin
                if (!result_valid || result_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // a finished count never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!result_valid || result_ready))
        else $error("result register overwritten");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready) |=> !pixel_ready)
        else $error("new item taken while busy");

    // an update step always follows a multiply step
    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER_UPD) |-> $past(state_reg == ST_ITER_MUL))
        else $error("update step without its products");

endmodule

// ----- design/mandelbrot_escape_iteration.sv -----
// Mandelbrot escape-time unit for one pixel with known-region early exit.
// Each item (column, row) is mapped to c = (-2 + column*x_step, -1.125 + row*y_step)
// in signed Q4.28; points inside the two radius-1/4 discs or the main cardioid
// return max_iter right away, all others iterate z = z*z + c until |z|^2 >= 4
// or the count reaches max_iter. One pixel is in flight at a time. After the
// decision step a known-inside point goes to the output register; any other
// point loops over a multiply step through the three shared 33x33 multipliers,
// where the limit is checked, and a step for the escape test and z update.
// The next pixel can be accepted while a finished count waits in the output
// register. Configuration writes land at once and should only be made while
// no pixel is in progress.
module mandelbrot_escape_iteration
    import mbe_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [IDX_W-1:0]    column,
    input  logic [IDX_W-1:0]    row,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [COUNT_W-1:0]  iteration_count,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [STEP_W-1:0]   cfg_data
);

    localparam logic [1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [1:0] CFG_X_STEP   = 2'd1;
    localparam logic [1:0] CFG_Y_STEP   = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_ITER_RST = 25'd524288;
    localparam logic [STEP_W-1:0]  X_STEP_RST   = 30'd1007917;
    localparam logic [STEP_W-1:0]  Y_STEP_RST   = 30'd1008337;

    logic [COUNT_W-1:0] max_iter_reg;
    logic [STEP_W-1:0]  x_step_reg, y_step_reg;
    logic               result_valid_reg;
    logic [COUNT_W-1:0] iteration_count_reg;
    logic [COUNT_W-1:0] count;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            x_step_reg   <= X_STEP_RST;
            y_step_reg   <= Y_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ITER: max_iter_reg <= cfg_data[COUNT_W-1:0];
                CFG_X_STEP:   x_step_reg   <= cfg_data;
                CFG_Y_STEP:   y_step_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.load_result)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
            iteration_count_reg <= count;
    end

    assign result_valid    = result_valid_reg;
    assign iteration_count = iteration_count_reg;

    mbe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid_reg),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mbe_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .column   (column),
        .row      (row),
        .max_iter (max_iter_reg),
        .x_step   (x_step_reg),
        .y_step   (y_step_reg),
        .count    (count)
    );

    // a delivered count never exceeds the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> iteration_count <= max_iter_reg)
        else $error("count above iteration limit");

endmodule
